[hdl/voltage_band_color_gradient_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the voltage band color gradient unit
// Expect clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef VOLTAGE_BAND_COLOR_GRADIENT_UNIT_ASSERT_SVH
`define VOLTAGE_BAND_COLOR_GRADIENT_UNIT_ASSERT_SVH

// same-cycle implication
`define VBCG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VBCG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vbcg_pkg.sv]
// ----------------------------------------------------------------------------
// vbcg_pkg
// Types and constants of the voltage band color gradient unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vbcg_pkg;

  localparam int FRAC_BITS = 12;
  localparam int F_W       = FRAC_BITS + 1;   // fraction incl. the value one
  localparam int LIM_W     = 16;              // unsigned band limit
  localparam int CMP_W     = LIM_W + 1;       // signed compare width
  localparam int LVL_W     = 15;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int RGB_W     = 24;
  localparam int PROD_W    = F_W + 10;        // 9-bit channel delta times fraction

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_V0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_V1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_V2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_V3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS_12   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS_34   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_FIVE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND  = 3'd7;

  localparam logic [LVL_W-1:0] RST_LEVEL_V0 = 15'd3809;
  localparam logic [LVL_W-1:0] RST_LEVEL_V1 = 15'd3891;
  localparam logic [LVL_W-1:0] RST_LEVEL_V2 = 15'd4260;
  localparam logic [LVL_W-1:0] RST_LEVEL_V3 = 15'd4301;

  localparam logic [LIM_W-1:0] LIM_FIVE = LIM_W'(5 << FRAC_BITS);
  localparam logic [CMP_W-1:0] TWO_Q    = CMP_W'(2 << FRAC_BITS);
  localparam logic [F_W-1:0]   ONE_Q    = F_W'(1 << FRAC_BITS);

  // floor(x / 5) == (x * RECIP5) >> RECIP5_SH for x < 2**18
  localparam int               RECIP5_SH = 18;
  localparam logic [15:0]      RECIP5    = 16'd52429;

  localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFFFFFF;

  typedef struct packed {
    logic               has_value;
    logic signed [15:0] voltage;
  } vbcg_in_t;

  typedef struct packed {
    logic [RGB_W-1:0] pixel_color;
    logic             color_written;
  } vbcg_out_t;

  // control that rides along the pipe with each word
  typedef struct packed {
    logic       has_value;
    logic       match;
    logic [2:0] band;
    logic       f_zero;
    logic       f_one;
  } vbcg_side_t;

endpackage

[hdl/voltage_band_color_gradient_unit.sv]
// Throughput: one word per cycle while in_stall is low; the fraction divider is a chain of
// FRAC_BITS one-bit restoring stages, one quotient bit per stage.
// A two-entry output (register + skid) keeps in_stall a registered signal.
// Reset (rst_n low, synchronous): pipe and output emptied, registers to defaults.
// ----------------------------------------------------------------------------
// voltage_band_color_gradient_unit
// Maps a cell voltage to a color by linear blending inside eight bands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voltage_band_color_gradient_unit_assert.svh"

module voltage_band_color_gradient_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vbcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vbcg_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vbcg_pkg::vbcg_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vbcg_pkg::vbcg_out_t            out_data
);
  import vbcg_pkg::*;

  // ---------------- configuration ----------------
  logic [LVL_W-1:0] level_v0_r, level_v1_r, level_v2_r, level_v3_r;
  logic [CFG_W-1:0] colors_12_r, colors_34_r;
  logic [RGB_W-1:0] color_five_r, background_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_v0_r   <= RST_LEVEL_V0;
      level_v1_r   <= RST_LEVEL_V1;
      level_v2_r   <= RST_LEVEL_V2;
      level_v3_r   <= RST_LEVEL_V3;
      colors_12_r  <= '0;
      colors_34_r  <= '0;
      color_five_r <= '0;
      background_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_V0:   level_v0_r   <= cfg_wdata[LVL_W-1:0];
        REG_LEVEL_V1:   level_v1_r   <= cfg_wdata[LVL_W-1:0];
        REG_LEVEL_V2:   level_v2_r   <= cfg_wdata[LVL_W-1:0];
        REG_LEVEL_V3:   level_v3_r   <= cfg_wdata[LVL_W-1:0];
        REG_COLORS_12:  colors_12_r  <= cfg_wdata;
        REG_COLORS_34:  colors_34_r  <= cfg_wdata;
        REG_COLOR_FIVE: color_five_r <= cfg_wdata[RGB_W-1:0];
        REG_BACKGROUND: background_r <= cfg_wdata[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // derived limits, recomputed every cycle; the user must send no word before they settle, not enforced
  logic [17:0]      v0x4, v3x6;
  logic [33:0]      lim1_prod, lim7_prod;
  logic [LIM_W-1:0] lim1_r, lim3_r, lim7_r;
  logic [LIM_W-1:0] lim1_nxt, lim3_nxt, lim7_nxt;
  logic [LIM_W-1:0] lim [0:8];
  logic [RGB_W-1:0] col [0:8];

  always_comb begin
    v0x4      = {1'b0, level_v0_r, 2'b00};
    v3x6      = {1'b0, level_v3_r, 2'b00} + {2'b00, level_v3_r, 1'b0};
    lim1_prod = 34'(v0x4) * 34'(RECIP5);
    lim7_prod = 34'(v3x6) * 34'(RECIP5);
    lim1_nxt  = lim1_prod[RECIP5_SH +: LIM_W];
    lim7_nxt  = lim7_prod[RECIP5_SH +: LIM_W];
    lim3_nxt  = ({1'b0, level_v0_r} + {1'b0, level_v1_r}) >> 1;
  end

  always_ff @(posedge clk) begin
    lim1_r <= lim1_nxt;
    lim3_r <= lim3_nxt;
    lim7_r <= lim7_nxt;
  end

  always_comb begin
    lim[0] = '0;
    lim[1] = lim1_r;
    lim[2] = {1'b0, level_v0_r};
    lim[3] = lim3_r;
    lim[4] = {1'b0, level_v1_r};
    lim[5] = {1'b0, level_v2_r};
    lim[6] = {1'b0, level_v3_r};
    lim[7] = lim7_r;
    lim[8] = LIM_FIVE;
    col[0] = WHITE_RGB;
    col[1] = colors_12_r[RGB_W-1:0];
    col[2] = colors_12_r[RGB_W-1:0];
    col[3] = colors_12_r[CFG_W-1:RGB_W];
    col[4] = colors_12_r[CFG_W-1:RGB_W];
    col[5] = colors_34_r[RGB_W-1:0];
    col[6] = colors_34_r[CFG_W-1:RGB_W];
    col[7] = color_five_r;
    col[8] = WHITE_RGB;
  end

  // ---------------- pipe control ----------------
  logic skid_full_r;
  logic en;

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  // ---------------- stage 1: input word ----------------
  logic     s1_valid_r;
  vbcg_in_t s1_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (en) s1_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) s1_in_r <= in_data;
  end

  // ---------------- stage 2: compare against upper limits ----------------
  logic                    s2_valid_r;
  vbcg_in_t                s2_in_r;
  logic [7:0]              s2_lt_r, s2_lt_nxt;
  logic                    s2_gt2_r, s2_gt2_nxt;
  logic signed [CMP_W-1:0] s1_vs;

  always_comb begin
    s1_vs = CMP_W'(s1_in_r.voltage);
    for (int k = 0; k < 8; k++) begin
      s2_lt_nxt[k] = s1_vs < $signed({1'b0, lim[k+1]});
    end
    s2_gt2_nxt = s1_vs > $signed(TWO_Q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else if (en) s2_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_in_r  <= s1_in_r;
      s2_lt_r  <= s2_lt_nxt;
      s2_gt2_r <= s2_gt2_nxt;
    end
  end

  // ---------------- stage 3: band select, divider operands ----------------
  // stage 0 of the divider arrays is this stage
  logic             dv_valid_r [0:FRAC_BITS];
  vbcg_side_t       dv_side_r  [0:FRAC_BITS];
  logic [LIM_W-1:0] dv_rem_r   [0:FRAC_BITS];
  logic [LIM_W-1:0] dv_den_r   [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] dv_q_r [0:FRAC_BITS];

  vbcg_side_t       dv_side_nxt [0:FRAC_BITS];
  logic [LIM_W-1:0] dv_rem_nxt  [0:FRAC_BITS];
  logic [LIM_W-1:0] dv_den_nxt  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] dv_q_nxt [0:FRAC_BITS];

  vbcg_side_t       s3_side;
  logic [LIM_W-1:0] s3_lo, s3_hi, s3_num, s3_den, s3_v;

  always_comb begin
    s3_side           = '0;
    s3_side.has_value = s2_in_r.has_value;
    s3_side.match     = |s2_lt_r;
    for (int k = 7; k >= 0; k--) begin
      if (s2_lt_r[k]) s3_side.band = 3'(k);
    end
    s3_lo  = lim[{1'b0, s3_side.band}];
    s3_hi  = lim[{1'b0, s3_side.band} + 4'd1];
    s3_v   = s2_in_r.voltage[LIM_W-1:0];
    s3_num = s3_v - s3_lo;
    s3_den = s3_hi - s3_lo;
    // below zero -> 0; above two -> 1; empty band -> 0;
    // reversed limits -> quotient saturates at 1; below lower limit -> 0
    if (s2_in_r.voltage[15]) begin
      s3_side.f_zero = 1'b1;
    end else if (s2_gt2_r) begin
      s3_side.f_one = 1'b1;
    end else if (s3_lo == s3_hi) begin
      s3_side.f_zero = 1'b1;
    end else if (s3_lo > s3_hi) begin
      s3_side.f_one = 1'b1;
    end else if (s3_v < s3_lo) begin
      s3_side.f_zero = 1'b1;
    end
  end

  // one restoring step per stage; remainder stays below the divisor when the voltage is inside its band
  logic [LIM_W:0] dv_t   [0:FRAC_BITS-1];
  logic [LIM_W:0] dv_sub [0:FRAC_BITS-1];
  logic           dv_ge  [0:FRAC_BITS-1];

  always_comb begin
    dv_side_nxt[0] = s3_side;
    dv_rem_nxt[0]  = s3_num;
    dv_den_nxt[0]  = s3_den;
    dv_q_nxt[0]    = '0;
    for (int k = 0; k < FRAC_BITS; k++) begin
      dv_t[k]          = {dv_rem_r[k], 1'b0};
      dv_sub[k]        = dv_t[k] - {1'b0, dv_den_r[k]};
      dv_ge[k]         = dv_t[k] >= {1'b0, dv_den_r[k]};
      dv_side_nxt[k+1] = dv_side_r[k];
      dv_den_nxt[k+1]  = dv_den_r[k];
      dv_rem_nxt[k+1]  = dv_ge[k] ? dv_sub[k][LIM_W-1:0] : dv_t[k][LIM_W-1:0];
      dv_q_nxt[k+1]    = {dv_q_r[k][FRAC_BITS-2:0], dv_ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= FRAC_BITS; k++) dv_valid_r[k] <= 1'b0;
    end else if (en) begin
      dv_valid_r[0] <= s2_valid_r;
      for (int k = 1; k <= FRAC_BITS; k++) dv_valid_r[k] <= dv_valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= FRAC_BITS; k++) begin
        dv_side_r[k] <= dv_side_nxt[k];
        dv_rem_r[k]  <= dv_rem_nxt[k];
        dv_den_r[k]  <= dv_den_nxt[k];
        dv_q_r[k]    <= dv_q_nxt[k];
      end
    end
  end

  // ---------------- color select stage ----------------
  logic             c_valid_r;
  vbcg_side_t       c_side_r;
  logic [F_W-1:0]   c_f_r, c_f_nxt;
  logic [RGB_W-1:0] c_ca_r, c_cb_r;
  vbcg_side_t       dv_last;

  always_comb begin
    dv_last = dv_side_r[FRAC_BITS];
    if (dv_last.f_zero)     c_f_nxt = '0;
    else if (dv_last.f_one) c_f_nxt = ONE_Q;
    else                    c_f_nxt = {1'b0, dv_q_r[FRAC_BITS]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else if (en) c_valid_r <= dv_valid_r[FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= dv_last;
      c_f_r    <= c_f_nxt;
      c_ca_r   <= col[{1'b0, dv_last.band}];
      c_cb_r   <= col[{1'b0, dv_last.band} + 4'd1];
    end
  end

  // ---------------- blend multiply stage ----------------
  // ((ONE - f) * a + f * b) >> FB == a + floor(f * (b - a) / ONE)
  logic                     m_valid_r;
  vbcg_side_t               m_side_r;
  logic [RGB_W-1:0]         m_ca_r;
  logic signed [PROD_W-1:0] m_prod_r   [0:2];
  logic signed [PROD_W-1:0] m_prod_nxt [0:2];
  logic signed [8:0]        c_diff     [0:2];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      c_diff[ch]     = $signed({1'b0, c_cb_r[8*ch +: 8]}) - $signed({1'b0, c_ca_r[8*ch +: 8]});
      m_prod_nxt[ch] = c_diff[ch] * $signed({1'b0, c_f_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_valid_r <= 1'b0;
    else if (en) m_valid_r <= c_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side_r <= c_side_r;
      m_ca_r   <= c_ca_r;
      for (int ch = 0; ch < 3; ch++) m_prod_r[ch] <= m_prod_nxt[ch];
    end
  end

  // ---------------- result and output buffer ----------------
  logic signed [PROD_W-1:0] m_shift [0:2];
  logic [RGB_W-1:0]         m_blend;
  vbcg_out_t                res;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      m_shift[ch]         = m_prod_r[ch] >>> FRAC_BITS;
      m_blend[8*ch +: 8]  = m_ca_r[8*ch +: 8] + m_shift[ch][7:0];
    end
    if (!m_side_r.has_value) begin
      res.pixel_color   = background_r;
      res.color_written = 1'b1;
    end else if (!m_side_r.match) begin
      res.pixel_color   = '0;
      res.color_written = 1'b0;
    end else begin
      res.pixel_color   = m_blend;
      res.color_written = 1'b1;
    end
  end

  logic      out_valid_r, out_valid_nxt;
  logic      skid_full_nxt;
  vbcg_out_t out_data_r, out_data_nxt;
  vbcg_out_t skid_data_r, skid_data_nxt;
  logic      take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (skid_full_r) begin
      // pipe is frozen; drain the skid word once the output moves
      if (take) begin
        out_data_nxt  = skid_data_r;
        skid_full_nxt = 1'b0;
      end
    end else if (m_valid_r) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_full_nxt = 1'b1;
        skid_data_nxt = res;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  `VBCG_ASSERT_IMP(a_skid_behind_out, skid_full_r, out_valid_r, "skid word without output word")
  `VBCG_ASSERT_NXT(a_take_drains_skid, take, !skid_full_r, "skid still full after a take")
  `VBCG_ASSERT_IMP(a_frac_le_one, c_valid_r, c_f_r <= ONE_Q, "blend fraction above one")
  `VBCG_ASSERT_NXT(a_frozen_pipe, skid_full_r && out_stall, $stable(c_f_r) && $stable(m_valid_r), "pipe moved while frozen")

endmodule
